[hdl/pla_pkg.sv]
// Shared types and constants for the PLA Mealy machine step block.
// Holds the input and result payload structs, command codes and default sizes.
// No dependencies.
package pla_pkg;

    localparam int INPUT_BITS_DEF         = 3;
    localparam int STATE_BITS_DEF         = 3;
    localparam int OUTPUT_COUNT_DEF       = 5;
    localparam int CUBES_PER_FUNCTION_DEF = 16;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_STEP = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] function_index;
        logic [3:0] cube_slot;
        logic [5:0] cube_care;
        logic [5:0] cube_bits;
        logic       cube_enable;
        logic [3:0] start_state;
        logic [3:0] input_symbol;
    } in_item_t;

    typedef struct packed {
        logic [3:0] present_state;
        logic [2:0] output_number;
        logic [3:0] next_state;
        logic [2:0] active_outputs;
    } out_item_t;

endpackage

[hdl/pla_mealy_machine_step.sv]
// Top level of the PLA Mealy machine step block: cube memory, slot scan, result register.
// Depends on pla_pkg (payload structs, command codes, default sizes).
//
// Channel | Dir | Handshake          | Payload
// s_      | in  | s_valid / s_ready  | s_data (pla_pkg::in_item_t)
// m_      | out | m_valid / m_ready  | m_data (pla_pkg::out_item_t)
//
// Load and set items are taken in the idle state; a step scans every slot of the cube memory.
// The step time is set by the cube memory: one row (one slot of every function) is
// read per cycle, then the registered read data is folded in and the result is formed.
// After reset a clearing pass zeroes every row of the memory; s_ready is low.
// A result waits in the output register; a step finishing while it is still held stalls.
module pla_mealy_machine_step #(
    parameter int INPUT_BITS         = pla_pkg::INPUT_BITS_DEF,
    parameter int STATE_BITS         = pla_pkg::STATE_BITS_DEF,
    parameter int OUTPUT_COUNT       = pla_pkg::OUTPUT_COUNT_DEF,
    parameter int CUBES_PER_FUNCTION = pla_pkg::CUBES_PER_FUNCTION_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pla_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pla_pkg::out_item_t  m_data
);

    localparam int FN_COUNT = STATE_BITS + OUTPUT_COUNT;
    localparam int VEC_W    = INPUT_BITS + STATE_BITS;
    localparam int FN_W     = (FN_COUNT > 1) ? $clog2(FN_COUNT) : 1;
    localparam int SLOT_W   = (CUBES_PER_FUNCTION > 1) ? $clog2(CUBES_PER_FUNCTION) : 1;
    localparam int CNT_W    = $clog2(OUTPUT_COUNT + 1);

    typedef struct packed {
        logic             en;
        logic [VEC_W-1:0] care;
        logic [VEC_W-1:0] bits;
    } cube_t;

    typedef cube_t [FN_COUNT-1:0] row_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [SLOT_W-1:0]       slot_cnt_reg;
    logic [STATE_BITS-1:0]   state_code_reg;
    logic [VEC_W-1:0]        vec_reg;
    logic [FN_COUNT-1:0]     hit_reg;
    logic                    rd_vld_reg;
    row_t                    rd_row_reg;
    logic                    m_valid_reg;
    pla_pkg::out_item_t      m_data_reg;

    row_t                    mem [CUBES_PER_FUNCTION];

    logic                    in_xfer;
    logic                    step_go;
    logic                    slot_last;
    logic                    clr_we;
    logic                    ld_we;
    logic                    rd_en;
    logic                    fin_go;
    logic [FN_W-1:0]         ld_fn;
    logic [SLOT_W-1:0]       ld_slot;
    cube_t                   ld_entry;
    logic [31:0]             start_dec;
    logic [31:0]             sym_dec;
    logic [FN_COUNT-1:0]     match;
    logic [FN_COUNT-1:0]     hit_next;
    logic [OUTPUT_COUNT-1:0] out_hits;
    logic [CNT_W-1:0]        active;
    logic [CNT_W-1:0]        number;
    logic [31:0]             present_inc;
    logic [31:0]             next_inc;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign step_go   = in_xfer && (s_data.command == pla_pkg::CMD_STEP);
    assign slot_last = (32'(slot_cnt_reg) == CUBES_PER_FUNCTION - 1);
    assign clr_we    = (state_reg == ST_CLEAR);
    assign rd_en     = (state_reg == ST_SCAN);
    assign fin_go    = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Load decode: drop writes outside the table
    assign ld_we = in_xfer && (s_data.command == pla_pkg::CMD_LOAD)
                   && (32'(s_data.function_index) < FN_COUNT)
                   && (32'(s_data.cube_slot) < CUBES_PER_FUNCTION);
    assign ld_fn          = FN_W'(s_data.function_index);
    assign ld_slot        = SLOT_W'(s_data.cube_slot);
    assign ld_entry.en    = s_data.cube_enable;
    assign ld_entry.care  = VEC_W'(32'(s_data.cube_care));
    assign ld_entry.bits  = VEC_W'(32'(s_data.cube_bits));

    assign start_dec = 32'(s_data.start_state) - 32'd1;
    assign sym_dec   = 32'(s_data.input_symbol) - 32'd1;

    // Cube memory: one row per slot, one lane per function
    always_ff @(posedge aclk) begin
        if (clr_we) begin
            mem[slot_cnt_reg] <= '0;
        end else if (ld_we) begin
            mem[ld_slot][ld_fn] <= ld_entry;
        end
        if (rd_en) begin
            rd_row_reg <= mem[slot_cnt_reg];
        end
    end

    always_comb begin
        for (int f = 0; f < FN_COUNT; f++) begin
            match[f] = rd_row_reg[f].en
                       && (((vec_reg ^ rd_row_reg[f].bits) & rd_row_reg[f].care) == '0);
        end
        // start a step with an empty hit vector
        if (step_go) begin
            hit_next = '0;
        end else begin
            hit_next = rd_vld_reg ? (hit_reg | match) : hit_reg;
        end
    end

    // Result assembly from the finished hit vector
    always_comb begin
        out_hits = hit_reg[FN_COUNT-1:STATE_BITS];
        active   = CNT_W'($countones(out_hits));
        number   = '0;
        for (int j = 0; j < OUTPUT_COUNT; j++) begin
            if (out_hits[j]) begin
                number = CNT_W'(j + 1);
            end
        end
        if (active != CNT_W'(1)) begin
            number = '0;
        end
        present_inc = 32'(state_code_reg) + 32'd1;
        next_inc    = 32'(hit_reg[STATE_BITS-1:0]) + 32'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            slot_cnt_reg   <= '0;
            state_code_reg <= '0;
            rd_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            rd_vld_reg <= rd_en;
            hit_reg    <= hit_next;
            if (m_valid_reg && m_ready && !fin_go) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    if (slot_last) begin
                        slot_cnt_reg <= '0;
                        state_reg    <= ST_IDLE;
                    end else begin
                        slot_cnt_reg <= slot_cnt_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (in_xfer && s_data.command == pla_pkg::CMD_SET) begin
                        state_code_reg <= start_dec[STATE_BITS-1:0];
                    end
                    if (step_go) begin
                        vec_reg      <= {sym_dec[INPUT_BITS-1:0], state_code_reg};
                        slot_cnt_reg <= '0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (slot_last) begin
                        slot_cnt_reg <= '0;
                        state_reg    <= ST_WAIT;
                    end else begin
                        slot_cnt_reg <= slot_cnt_reg + 1'b1;
                    end
                end
                ST_WAIT: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    // hold the result until the output register frees up
                    if (fin_go) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.present_state   <= present_inc[3:0];
                        m_data_reg.output_number   <= 3'(32'(number));
                        m_data_reg.next_state      <= next_inc[3:0];
                        m_data_reg.active_outputs  <= 3'(32'(active));
                        state_code_reg             <= hit_reg[STATE_BITS-1:0];
                        state_reg                  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_rd_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> $past(state_reg == ST_SCAN))
        else $error("read data valid without a scan cycle");

    a_result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    a_state_code_change: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(state_code_reg) |->
            ($past(in_xfer && s_data.command == pla_pkg::CMD_SET) || $past(fin_go)))
        else $error("state code changed without set or step completion");

    a_hits_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && !fin_go) |=> $stable(hit_reg))
        else $error("hit vector moved while result stalled");

endmodule
